@@ design/ghtab_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Generational handle table package
// Shared word types, opcode and status codes, and the command and status
// bundles that join the controller and the datapath.
// ----------------------------------------------------------------------------
package ghtab_pkg;

	localparam int SLOT_COUNT_DEF = 256;
	localparam int GEN_BITS_DEF   = 32;
	localparam int TAG_BITS_DEF   = 32;

	localparam int OP_W     = 2;
	localparam int STATUS_W = 2;
	localparam int SLOT_W   = 9;
	localparam int GEN_W    = 32;
	localparam int TAG_W    = 32;

	localparam logic [OP_W-1:0] OP_ALLOC  = 2'd0;
	localparam logic [OP_W-1:0] OP_LOOKUP = 2'd1;
	localparam logic [OP_W-1:0] OP_REMOVE = 2'd2;
	localparam logic [OP_W-1:0] OP_CLEAR  = 2'd3;

	localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] ST_BAD   = 2'd1;
	localparam logic [STATUS_W-1:0] ST_STALE = 2'd2;
	localparam logic [STATUS_W-1:0] ST_FULL  = 2'd3;

	typedef struct packed {
		logic [OP_W-1:0]   opcode;
		logic [SLOT_W-1:0] handle_slot;
		logic [GEN_W-1:0]  handle_generation;
		logic [TAG_W-1:0]  record_tag;
	} req_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [SLOT_W-1:0]   out_slot;
		logic [GEN_W-1:0]    out_generation;
		logic [TAG_W-1:0]    found_tag;
		logic [SLOT_W-1:0]   slots_created;
	} rsp_t;

	typedef struct packed {
		logic latch;
		logic addr;
		logic stk;
		logic commit;
	} cmd_t;

	typedef struct packed {
		logic [OP_W-1:0] opcode;
		logic            free_avail;
		logic            out_free;
	} sts_t;

endpackage
`default_nettype wire

@@ design/ghtab_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Generational handle table controller
// Sequences one request word through address, free-stack pop (reused-slot allocates only) and commit.
// ----------------------------------------------------------------------------
module ghtab_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              req_valid,
	output logic                   req_ready,
	input  wire ghtab_pkg::sts_t   sts,
	output ghtab_pkg::cmd_t        cmd
);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_ADDR = 2'd1;
	localparam logic [1:0] S_STK  = 2'd2;
	localparam logic [1:0] S_EXEC = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_d;
	logic       accept;

	assign req_ready  = (state_q == S_IDLE);
	assign accept     = req_valid && req_ready;
	assign cmd.latch  = accept;
	assign cmd.addr   = (state_q == S_ADDR);
	assign cmd.stk    = (state_q == S_STK);
	assign cmd.commit = (state_q == S_EXEC) && sts.out_free;

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (accept) state_d = S_ADDR;
			end
			S_ADDR: begin
				// A reused slot needs its index from the free stack first.
				if (sts.opcode == ghtab_pkg::OP_ALLOC && sts.free_avail) state_d = S_STK;
				else state_d = S_EXEC;
			end
			S_STK: begin
				state_d = S_EXEC;
			end
			S_EXEC: begin
				if (sts.out_free) state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	a_accept_to_addr: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q == S_ADDR)
		else $error("accepted word did not move to address state");

	a_stk_after_alloc: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_STK |-> $past(state_q) == S_ADDR &&
			$past(sts.opcode) == ghtab_pkg::OP_ALLOC)
		else $error("free-stack pop outside of an allocate");

	a_commit_to_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |=> state_q == S_IDLE)
		else $error("commit did not return to idle");

endmodule
`default_nettype wire

@@ design/ghtab_dp.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Generational handle table datapath
// Slot memory (generation plus in-use bit), tag memory, free stack, counters
// and the response register.
// ----------------------------------------------------------------------------
module ghtab_dp #(
	parameter int SLOT_COUNT = ghtab_pkg::SLOT_COUNT_DEF,
	parameter int GEN_BITS   = ghtab_pkg::GEN_BITS_DEF,
	parameter int TAG_BITS   = ghtab_pkg::TAG_BITS_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire ghtab_pkg::req_t   req,
	input  wire ghtab_pkg::cmd_t   cmd,
	output ghtab_pkg::sts_t        sts,
	output logic                   rsp_valid,
	input  wire logic              rsp_ready,
	output ghtab_pkg::rsp_t        rsp
);

	localparam int IDXW = $clog2(SLOT_COUNT);
	localparam int CNTW = $clog2(SLOT_COUNT + 1);
	localparam int CMPW = CNTW + ghtab_pkg::SLOT_W;
	localparam int OSLW = IDXW + ghtab_pkg::SLOT_W;
	localparam int GXW  = GEN_BITS + ghtab_pkg::GEN_W;
	localparam int TXW  = TAG_BITS + ghtab_pkg::TAG_W;
	localparam logic [CNTW-1:0] SLOT_MAX = CNTW'(SLOT_COUNT);

	// Slot word: in-use bit above the generation.
	logic [GEN_BITS:0]   gen_mem [SLOT_COUNT];
	logic [TAG_BITS-1:0] tag_mem [SLOT_COUNT];
	logic [IDXW-1:0]     stk_mem [SLOT_COUNT];

	ghtab_pkg::req_t     req_q;
	ghtab_pkg::rsp_t     rsp_q;
	ghtab_pkg::rsp_t     rsp_d;
	logic                rsp_valid_q;
	logic [IDXW-1:0]     idx_q;
	logic                from_stk_q;
	logic [CNTW-1:0]     created_q;
	logic [CNTW-1:0]     created_d;
	logic [CNTW-1:0]     free_q;
	logic [CNTW-1:0]     free_d;
	logic [CNTW-1:0]     free_dec;
	logic [GEN_BITS:0]   gen_rd_q;
	logic [TAG_BITS-1:0] tag_rd_q;
	logic [IDXW-1:0]     stk_rd_q;

	logic                out_free;
	logic                pop;
	logic [CMPW-1:0]     hidx_w;
	logic [IDXW-1:0]     hidx;
	logic [IDXW-1:0]     gen_raddr;
	logic                bad;
	logic                stale;
	logic [GXW-1:0]      hgen_x;
	logic [GEN_BITS-1:0] gen_inc;
	logic [GEN_BITS-1:0] gen_next;
	logic [GEN_BITS-1:0] alloc_gen;
	logic [OSLW-1:0]     oslot_x;
	logic [GXW-1:0]      ogen_x;
	logic [TXW-1:0]      ftag_x;
	logic [TXW-1:0]      tag_x;
	logic [CMPW-1:0]     cnt_x;

	logic                gen_we;
	logic [GEN_BITS:0]   gen_wdata;
	logic                tag_we;
	logic                stk_we;

	assign out_free = !rsp_valid_q || rsp_ready;
	assign sts.opcode     = req_q.opcode;
	assign sts.free_avail = (free_q != '0);
	assign sts.out_free   = out_free;
	assign rsp_valid      = rsp_valid_q;
	assign rsp            = rsp_q;

	assign pop       = (req_q.opcode == ghtab_pkg::OP_ALLOC) && (free_q != '0);
	assign free_dec  = free_q - CNTW'(1);
	assign hidx_w    = CMPW'(req_q.handle_slot) - CMPW'(1);
	assign hidx      = hidx_w[IDXW-1:0];
	assign gen_raddr = cmd.stk ? stk_rd_q : hidx;

	assign bad = (req_q.handle_slot == '0) ||
		(CMPW'(req_q.handle_slot) > CMPW'(created_q));
	assign hgen_x = GXW'(req_q.handle_generation);
	assign stale  = !gen_rd_q[GEN_BITS] || (gen_rd_q[GEN_BITS-1:0] != hgen_x[GEN_BITS-1:0]);

	// Generation counts up modulo 2^GEN_BITS and never takes the value zero.
	assign gen_inc   = gen_rd_q[GEN_BITS-1:0] + GEN_BITS'(1);
	assign gen_next  = (gen_inc == '0) ? GEN_BITS'(1) : gen_inc;
	assign alloc_gen = from_stk_q ? gen_next : GEN_BITS'(1);

	assign oslot_x = OSLW'(idx_q) + OSLW'(1);
	assign ogen_x  = GXW'(alloc_gen);
	assign ftag_x  = TXW'(tag_rd_q);
	assign tag_x   = TXW'(req_q.record_tag);
	assign cnt_x   = CMPW'(created_d);

	always_comb begin
		rsp_d     = '0;
		created_d = created_q;
		free_d    = free_q;
		gen_we    = 1'b0;
		gen_wdata = {1'b1, alloc_gen};
		tag_we    = 1'b0;
		stk_we    = 1'b0;
		case (req_q.opcode)
			ghtab_pkg::OP_ALLOC: begin
				if (from_stk_q || created_q != SLOT_MAX) begin
					if (!from_stk_q) created_d = created_q + CNTW'(1);
					gen_we               = 1'b1;
					tag_we               = 1'b1;
					rsp_d.out_slot       = oslot_x[ghtab_pkg::SLOT_W-1:0];
					rsp_d.out_generation = ogen_x[ghtab_pkg::GEN_W-1:0];
				end else begin
					rsp_d.status = ghtab_pkg::ST_FULL;
				end
			end
			ghtab_pkg::OP_LOOKUP: begin
				if (bad) rsp_d.status = ghtab_pkg::ST_BAD;
				else if (stale) rsp_d.status = ghtab_pkg::ST_STALE;
				else rsp_d.found_tag = ftag_x[ghtab_pkg::TAG_W-1:0];
			end
			ghtab_pkg::OP_REMOVE: begin
				if (bad) begin
					rsp_d.status = ghtab_pkg::ST_BAD;
				end else if (stale) begin
					rsp_d.status = ghtab_pkg::ST_STALE;
				end else begin
					gen_we    = 1'b1;
					gen_wdata = {1'b0, gen_next};
					if (free_q != SLOT_MAX) begin
						stk_we = 1'b1;
						free_d = free_q + CNTW'(1);
					end
				end
			end
			ghtab_pkg::OP_CLEAR: begin
				created_d = '0;
				free_d    = '0;
			end
			default: begin
				rsp_d = '0;
			end
		endcase
		rsp_d.slots_created = cnt_x[ghtab_pkg::SLOT_W-1:0];
	end

	// Memories: one write and one registered read per cycle each.
	always_ff @(posedge clk) begin
		if (cmd.commit && gen_we) gen_mem[idx_q] <= gen_wdata;
		if (cmd.addr || cmd.stk) gen_rd_q <= gen_mem[gen_raddr];
	end

	always_ff @(posedge clk) begin
		if (cmd.commit && tag_we) tag_mem[idx_q] <= tag_x[TAG_BITS-1:0];
		if (cmd.addr) tag_rd_q <= tag_mem[hidx];
	end

	always_ff @(posedge clk) begin
		if (cmd.commit && stk_we) stk_mem[free_q[IDXW-1:0]] <= idx_q;
		if (cmd.addr) stk_rd_q <= stk_mem[free_dec[IDXW-1:0]];
	end

	always_ff @(posedge clk) begin
		if (cmd.latch) req_q <= req;
		if (cmd.commit) rsp_q <= rsp_d;
		if (cmd.stk) begin
			idx_q <= stk_rd_q;
		end else if (cmd.addr) begin
			if (req_q.opcode == ghtab_pkg::OP_ALLOC) idx_q <= created_q[IDXW-1:0];
			else idx_q <= hidx;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			created_q   <= '0;
			free_q      <= '0;
			from_stk_q  <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cmd.addr) from_stk_q <= pop;
			if (cmd.addr && pop) begin
				free_q <= free_dec;
			end else if (cmd.commit) begin
				free_q <= free_d;
			end
			if (cmd.commit) created_q <= created_d;
			if (cmd.commit) rsp_valid_q <= 1'b1;
			else if (rsp_ready) rsp_valid_q <= 1'b0;
		end
	end

	a_free_le_created: assert property (@(posedge clk) disable iff (!arst_n)
		free_q <= created_q)
		else $error("free stack deeper than the number of created slots");

	a_created_bound: assert property (@(posedge clk) disable iff (!arst_n)
		created_q <= SLOT_MAX)
		else $error("created count beyond table size");

	a_full_means_full: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q && rsp_q.status == ghtab_pkg::ST_FULL |->
			free_q == '0 && created_q == SLOT_MAX)
		else $error("full status reported with room in the table");

endmodule
`default_nettype wire

@@ design/generational_handle_table.sv @@
`timescale 1ns / 1ps
`default_nettype none
// The request is latched on acceptance and the memories are read in the address
// state, with a free-stack read state added for a reused-slot allocate; the
// response word is registered at commit, which waits until the last is taken.
// A new request is taken only after commit; the slot memory is read registered
// and written back later. Reset clears the slot and free counts, the state
// and rsp_valid; memories are not swept, as no unwritten entry is used.
// ----------------------------------------------------------------------------
// Generational handle table
// Slot map with per-slot generation counters and a last-in first-out free
// list; allocate, lookup, remove and clear requests, one response each.
// ----------------------------------------------------------------------------
module generational_handle_table #(
	parameter int SLOT_COUNT = ghtab_pkg::SLOT_COUNT_DEF,
	parameter int GEN_BITS   = ghtab_pkg::GEN_BITS_DEF,
	parameter int TAG_BITS   = ghtab_pkg::TAG_BITS_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              req_valid,
	output logic                   req_ready,
	input  wire ghtab_pkg::req_t   req,
	output logic                   rsp_valid,
	input  wire logic              rsp_ready,
	output ghtab_pkg::rsp_t        rsp
);

	ghtab_pkg::cmd_t cmd;
	ghtab_pkg::sts_t sts;

	ghtab_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	ghtab_dp #(
		.SLOT_COUNT (SLOT_COUNT),
		.GEN_BITS   (GEN_BITS),
		.TAG_BITS   (TAG_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.cmd       (cmd),
		.sts       (sts),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

endmodule
`default_nettype wire
